@@ design/assert_macros.svh @@
// Assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/rtp_pkg.sv @@
package rtp_pkg;

    // Grammar positions after the fixed layout
    localparam logic [4:0] PH_AFTER_SEC  = 5'd19;
    localparam logic [4:0] PH_FRAC_FIRST = 5'd20;
    localparam logic [4:0] PH_FRAC_MORE  = 5'd21;
    localparam logic [4:0] PH_OFF_H0     = 5'd22;
    localparam logic [4:0] PH_OFF_H1     = 5'd23;
    localparam logic [4:0] PH_OFF_COLON  = 5'd24;
    localparam logic [4:0] PH_OFF_M0     = 5'd25;
    localparam logic [4:0] PH_OFF_M1     = 5'd26;
    localparam logic [4:0] PH_DONE       = 5'd27;

    localparam int EPOCH_W = 49;

    // Parsed fields of one string, handed from front to back
    typedef struct packed {
        logic        ok;
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [9:0]  milli;
        logic [10:0] off_min;
        logic        off_neg;
    } parsed_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_ERA,
        BK_DAYS,
        BK_MUL,
        BK_SUM,
        BK_OUT
    } bk_state_t;

    // Separator expected at each layout position, zero for a digit
    function automatic logic [7:0] layout_sep(input logic [4:0] ph);
        logic [7:0] s;
        begin
            case (ph)
                5'd4, 5'd7: s = 8'h2D;
                5'd10:      s = 8'h54;
                5'd13, 5'd16: s = 8'h3A;
                default:    s = 8'h00;
            endcase
            return s;
        end
    endfunction

    function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
        logic [4:0] d;
        begin
            case (m)
                4'd2: d = leap ? 5'd29 : 5'd28;
                4'd4, 4'd6, 4'd9, 4'd11: d = 5'd30;
                default: d = 5'd31;
            endcase
            return d;
        end
    endfunction

    // Days before the start of month m in a March-based year
    function automatic logic [8:0] doy_base(input logic [3:0] m);
        logic [8:0] d;
        begin
            case (m)
                4'd3:  d = 9'd0;
                4'd4:  d = 9'd31;
                4'd5:  d = 9'd61;
                4'd6:  d = 9'd92;
                4'd7:  d = 9'd122;
                4'd8:  d = 9'd153;
                4'd9:  d = 9'd184;
                4'd10: d = 9'd214;
                4'd11: d = 9'd245;
                4'd12: d = 9'd275;
                4'd1:  d = 9'd306;
                4'd2:  d = 9'd337;
                default: d = 9'd0;
            endcase
            return d;
        end
    endfunction

endpackage

@@ design/rtp_front.sv @@
// Character scanner: walks the grammar one character per cycle while the queue has room
module rtp_front
    import rtp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  char_code,
    input  logic        last,
    output logic        push,
    output parsed_t     push_data,
    input  logic        q_full
);

    logic [4:0]  phase_reg, phase_next;
    logic [13:0] field_reg, field_next;
    logic [13:0] year_reg, year_next;
    logic [6:0]  month_reg, month_next, day_reg, day_next;
    logic [6:0]  hour_reg, hour_next, min_reg, min_next, sec_reg, sec_next;
    logic [9:0]  milli_reg, milli_next;
    logic [1:0]  fdig_reg, fdig_next;
    logic [10:0] off_reg, off_next;
    logic        neg_reg, neg_next;
    logic        err_reg, err_next;

    logic        take;
    logic        is_dig;
    logic [3:0]  dv;
    logic [13:0] fv;
    logic [7:0]  sep;
    logic [9:0]  fadd;
    logic        leap, cal_ok;
    logic [4:0]  dim;
    logic [26:0] yprod;
    logic [7:0]  ycent;
    logic        ydiv100;

    assign in_ready = !q_full;
    assign take     = in_valid && in_ready;
    assign is_dig   = (char_code >= 8'h30) && (char_code <= 8'h39);
    assign dv       = char_code[3:0];
    assign fv       = 14'((field_reg << 3) + (field_reg << 1) + {10'd0, dv});
    assign sep      = layout_sep(phase_reg);

    always_comb
    begin
        case (fdig_reg)
            2'd0: fadd = 10'((dv << 6) + (dv << 5) + (dv << 2));
            2'd1: fadd = 10'((dv << 3) + (dv << 1));
            default: fadd = {6'd0, dv};
        endcase
    end

    // Grammar step
    always_comb
    begin
        phase_next = phase_reg; field_next = field_reg; year_next = year_reg;
        month_next = month_reg; day_next = day_reg; hour_next = hour_reg;
        min_next = min_reg; sec_next = sec_reg; milli_next = milli_reg;
        fdig_next = fdig_reg; off_next = off_reg; neg_next = neg_reg;
        err_next = err_reg;
        if (!err_reg)
        begin
            if (phase_reg < PH_AFTER_SEC)
            begin
                if (sep != 8'h00)
                begin
                    if (char_code == sep || (sep == 8'h54 && char_code == 8'h74))
                        phase_next = phase_reg + 5'd1;
                    else
                        err_next = 1'b1;
                end
                else if (!is_dig)
                    err_next = 1'b1;
                else
                begin
                    phase_next = phase_reg + 5'd1;
                    field_next = fv;
                    case (phase_reg)
                        5'd3:  begin year_next  = fv;      field_next = '0; end
                        5'd6:  begin month_next = fv[6:0]; field_next = '0; end
                        5'd9:  begin day_next   = fv[6:0]; field_next = '0; end
                        5'd12: begin hour_next  = fv[6:0]; field_next = '0; end
                        5'd15: begin min_next   = fv[6:0]; field_next = '0; end
                        5'd18: begin sec_next   = fv[6:0]; field_next = '0; end
                        default: ;
                    endcase
                end
            end
            else
            begin
                case (phase_reg)
                    PH_AFTER_SEC, PH_FRAC_MORE:
                    begin
                        if (phase_reg == PH_AFTER_SEC && char_code == 8'h2E)
                            phase_next = PH_FRAC_FIRST;
                        else if (phase_reg == PH_FRAC_MORE && is_dig)
                        begin
                            if (fdig_reg != 2'd3)
                            begin
                                milli_next = milli_reg + fadd;
                                fdig_next  = fdig_reg + 2'd1;
                            end
                        end
                        else if (char_code == 8'h5A || char_code == 8'h7A)
                            phase_next = PH_DONE;
                        else if (char_code == 8'h2B || char_code == 8'h2D)
                        begin
                            neg_next   = (char_code == 8'h2D);
                            phase_next = PH_OFF_H0;
                        end
                        else
                            err_next = 1'b1;
                    end
                    PH_FRAC_FIRST:
                    begin
                        if (!is_dig)
                            err_next = 1'b1;
                        else
                        begin
                            milli_next = milli_reg + fadd;
                            fdig_next  = fdig_reg + 2'd1;
                            phase_next = PH_FRAC_MORE;
                        end
                    end
                    PH_OFF_H0, PH_OFF_M0:
                    begin
                        if (!is_dig)
                            err_next = 1'b1;
                        else
                        begin
                            field_next = fv;
                            phase_next = phase_reg + 5'd1;
                        end
                    end
                    PH_OFF_H1:
                    begin
                        field_next = '0;
                        if (!is_dig || fv > 14'd23)
                            err_next = 1'b1;
                        else
                        begin
                            off_next   = 11'((fv << 6) - (fv << 2));
                            phase_next = PH_OFF_COLON;
                        end
                    end
                    PH_OFF_COLON:
                    begin
                        if (char_code != 8'h3A)
                            err_next = 1'b1;
                        else
                            phase_next = PH_OFF_M0;
                    end
                    PH_OFF_M1:
                    begin
                        field_next = '0;
                        if (!is_dig || fv > 14'd59)
                            err_next = 1'b1;
                        else
                        begin
                            off_next   = off_reg + 11'(fv);
                            phase_next = PH_DONE;
                        end
                    end
                    default: err_next = 1'b1;
                endcase
            end
        end
    end

    // Century test by reciprocal multiply; the year is final long before the terminator
    assign yprod   = 27'(year_reg) * 27'd5243;
    assign ycent   = yprod[26:19];
    assign ydiv100 = ((14'(ycent) * 14'd100) == year_reg);
    assign leap    = ((year_reg[1:0] == 2'b00) && !ydiv100)
                  || (ydiv100 && (ycent[1:0] == 2'b00));

    // Calendar check on the finished fields
    assign dim  = month_days(month_next[3:0], leap);
    assign cal_ok = (month_next >= 7'd1) && (month_next <= 7'd12) && (day_next >= 7'd1)
                 && (day_next <= {2'd0, dim}) && (hour_next <= 7'd23)
                 && (min_next <= 7'd59) && (sec_next <= 7'd59);

    assign push = take && last;
    always_comb
    begin
        push_data.ok      = !err_next && (phase_next == PH_DONE) && cal_ok;
        push_data.year    = year_next;
        push_data.month   = month_next[3:0];
        push_data.day     = day_next[4:0];
        push_data.hour    = hour_next[4:0];
        push_data.minute  = min_next[5:0];
        push_data.second  = sec_next[5:0];
        push_data.milli   = milli_next;
        push_data.off_min = off_next;
        push_data.off_neg = neg_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= '0; field_reg <= '0; year_reg <= '0; month_reg <= '0;
            day_reg <= '0; hour_reg <= '0; min_reg <= '0; sec_reg <= '0;
            milli_reg <= '0; fdig_reg <= '0; off_reg <= '0; neg_reg <= 1'b0;
            err_reg <= 1'b0;
        end
        else if (take)
        begin
            if (last)
            begin
                phase_reg <= '0; field_reg <= '0; year_reg <= '0; month_reg <= '0;
                day_reg <= '0; hour_reg <= '0; min_reg <= '0; sec_reg <= '0;
                milli_reg <= '0; fdig_reg <= '0; off_reg <= '0; neg_reg <= 1'b0;
                err_reg <= 1'b0;
            end
            else
            begin
                phase_reg <= phase_next; field_reg <= field_next; year_reg <= year_next;
                month_reg <= month_next; day_reg <= day_next; hour_reg <= hour_next;
                min_reg <= min_next; sec_reg <= sec_next; milli_reg <= milli_next;
                fdig_reg <= fdig_next; off_reg <= off_next; neg_reg <= neg_next;
                err_reg <= err_next;
            end
        end
    end

endmodule

@@ design/rtp_queue.sv @@
// Two-entry queue between scanner and epoch unit
module rtp_queue
    import rtp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  parsed_t push_data,
    output logic    full,
    output logic    not_empty,
    input  logic    pop,
    output parsed_t pop_data
);

    parsed_t    mem [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;

    assign full      = (cnt_reg == 2'd2);
    assign not_empty = (cnt_reg != 2'd0);
    assign pop_data  = mem[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wp_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= 1'b0; rp_reg <= 1'b0; cnt_reg <= '0;
        end
        else
        begin
            if (push) wp_reg <= !wp_reg;
            if (pop)  rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

@@ design/rtp_back.sv @@
// Epoch unit: days from date, then milliseconds, stepped through ERA, DAYS, MUL, SUM and OUT
module rtp_back
    import rtp_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      q_not_empty,
    input  parsed_t                   q_data,
    output logic                      q_pop,
    output logic                      res_valid,
    input  logic                      res_ready,
    output logic                      valid_res,
    output logic signed [EPOCH_W-1:0] epoch_ms
);

    bk_state_t state_reg, state_next;
    parsed_t   p_reg;
    logic [4:0] era_reg;
    logic [8:0] yoe_reg, doy_reg;
    logic signed [23:0] days_reg;
    logic signed [EPOCH_W-1:0] dms_reg, tms_reg, res_reg;
    logic ok_reg;

    // Year split into 400-year eras; divisions by reciprocal multiply
    logic [14:0] y;
    logic [15:0] era_prod;
    logic [4:0]  era;
    logic [8:0]  yoe;
    logic [8:0]  doy;
    logic [11:0] cent_prod;
    logic [1:0]  cent;
    logic [18:0] doe;
    assign y         = 15'(p_reg.year) + 15'd400 - ((p_reg.month <= 4'd2) ? 15'd1 : 15'd0);
    assign era_prod  = 16'(y[14:4]) * 16'd41;
    assign era       = era_prod[14:10];
    assign yoe       = 9'(y - 15'(era) * 15'd400);
    assign doy       = doy_base(p_reg.month) + 9'(p_reg.day) - 9'd1;

    // Day of era from the registered split
    assign cent_prod = 12'(yoe_reg[8:2]) * 12'd41;
    assign cent      = cent_prod[11:10];
    assign doe = 19'(yoe_reg) * 19'd365 + 19'(yoe_reg >> 2) - 19'(cent) + 19'(doy_reg);

    logic [16:0] tod_s;
    assign tod_s = 17'(p_reg.hour) * 17'd3600 + 17'(p_reg.minute) * 17'd60
                 + 17'(p_reg.second);

    always_comb
    begin
        state_next = state_reg;
        q_pop      = 1'b0;
        case (state_reg)
            BK_IDLE: if (q_not_empty) begin q_pop = 1'b1; state_next = BK_ERA; end
            BK_ERA:  state_next = BK_DAYS;
            BK_DAYS: state_next = BK_MUL;
            BK_MUL:  state_next = BK_SUM;
            BK_SUM:  state_next = BK_OUT;
            BK_OUT:  if (res_ready) state_next = BK_IDLE;
            default: state_next = BK_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= BK_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        if (q_pop) p_reg <= q_data;
        if (state_reg == BK_ERA)
        begin
            era_reg <= era;
            yoe_reg <= yoe;
            doy_reg <= doy;
        end
        if (state_reg == BK_DAYS)
            days_reg <= 24'sd146097 * 24'(era_reg) + 24'(doe) - 24'sd719468 - 24'sd146097;
        if (state_reg == BK_MUL)
        begin
            dms_reg <= EPOCH_W'(days_reg) * 49'sd86400000;
            tms_reg <= EPOCH_W'(tod_s) * 49'sd1000 + EPOCH_W'(p_reg.milli);
        end
        if (state_reg == BK_SUM)
        begin
            ok_reg <= p_reg.ok;
            if (!p_reg.ok)
                res_reg <= '0;
            else if (p_reg.off_neg)
                res_reg <= dms_reg + tms_reg + EPOCH_W'(p_reg.off_min) * 49'sd60000;
            else
                res_reg <= dms_reg + tms_reg - EPOCH_W'(p_reg.off_min) * 49'sd60000;
        end
    end

    assign res_valid = (state_reg == BK_OUT);
    assign valid_res = ok_reg;
    assign epoch_ms  = res_reg;

endmodule

@@ design/rfc3339_timestamp_parser.sv @@
// Path: the accepted last character enters the queue; the epoch unit then
// steps through ERA, DAYS, MUL and SUM to OUT, which drives out_valid.
// Throughput: one character per cycle while the queue has room; one result
// at a time in the epoch unit; a two-entry queue lets the scanner run ahead.
// Reset: rst_n asynchronous active low clears scanner, queue and
// sequencer; the parser then expects the first year digit.
module rfc3339_timestamp_parser
    import rtp_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [7:0]                char_code,
    input  logic                      last,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic                      valid_res,
    output logic signed [EPOCH_W-1:0] epoch_ms
);

    logic    push, full, not_empty, pop;
    parsed_t push_data, pop_data;

    rtp_front u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .char_code(char_code), .last(last), .push(push), .push_data(push_data),
        .q_full(full)
    );

    rtp_queue u_queue (
        .clk(clk), .rst_n(rst_n), .push(push), .push_data(push_data), .full(full),
        .not_empty(not_empty), .pop(pop), .pop_data(pop_data)
    );

    rtp_back u_back (
        .clk(clk), .rst_n(rst_n), .q_not_empty(not_empty), .q_data(pop_data),
        .q_pop(pop), .res_valid(out_valid), .res_ready(out_ready),
        .valid_res(valid_res), .epoch_ms(epoch_ms)
    );

endmodule

@@ design/rtp_checker.sv @@
`include "assert_macros.svh"

// Port-level checks of the parser
module rtp_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic        valid_res,
    input logic [48:0] epoch_ms
);

    `ASSERT_IMPLY(a_inv_zero, clk, rst_n, out_valid && !valid_res, epoch_ms == 49'd0, "invalid result not zero")
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(epoch_ms), "result dropped")
    `ASSERT_NEXT(a_out_gap, clk, rst_n, out_valid && out_ready, !out_valid, "results back to back")

endmodule

bind rfc3339_timestamp_parser rtp_checker u_rtp_checker (
    .clk(clk), .rst_n(rst_n),
    .out_valid(out_valid), .out_ready(out_ready), .valid_res(valid_res),
    .epoch_ms(epoch_ms)
);
